>>> rtl/core/cha_pkg.sv
// shared codes, field widths and result type of the channel hit accumulator
package cha_pkg;

    localparam int REQ_W     = 2;
    localparam int DET_W     = 4;
    localparam int CH_W      = 20;
    localparam int AMT_W     = 24;
    localparam int IDX_W     = 8;
    localparam int SUM_W     = 32;
    localparam int ECNT_W    = 9;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HIT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [ECNT_W-1:0] entry_count;
        logic [SUM_W-1:0]  read_sum;
        logic [CH_W-1:0]   read_channel;
        logic              read_valid;
        logic              saturated;
        logic              dropped;
        logic              merged;
    } res_t;

endpackage

>>> rtl/core/channel_hit_accumulator_top.sv
// channel hit accumulator: per-detector tables of fired channels with summed response
//
// Each detector owns a table of up to ENTRIES (channel, sum) entries held in two
// single-port-read synchronous memories, plus a fill count per detector in flops.
// A word on the slave side is one request: clear (count set to zero), accumulate
// hit, or read entry. A hit scans the detector's table one stored entry per cycle
// through the memory read port; on a match the sum is added back with saturation
// at 2^32-1, otherwise the channel is appended, or the hit is dropped if the table
// is full. The fill count bounds every scan and read, so the memories need no
// clearing pass after reset. One request is worked on at a time; the next one is
// taken as soon as the previous result sits in the output register, even while
// that result still waits for m_tready. Requests to a detector at or above
// NUM_DETECTORS answer with all fields zero; an unknown request reports the count.
module channel_hit_accumulator_top #(
    parameter int ENTRIES       = 256,
    parameter int NUM_DETECTORS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // detector[3:0], channel[23:4], amount[47:24], entry_index[55:48]
    input  logic [cha_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [cha_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // merged[0], dropped[1], saturated[2], read_valid[3], read_channel[23:4],
    // read_sum[55:24], entry_count[64:56], zero[71:65]
    output logic [cha_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DEPTH = NUM_DETECTORS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int DIW   = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
    localparam int CMPW  = (CW > cha_pkg::IDX_W) ? CW : cha_pkg::IDX_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    // input word fields
    logic [cha_pkg::REQ_W-1:0] in_req;
    logic [cha_pkg::DET_W-1:0] in_det;
    logic [cha_pkg::CH_W-1:0]  in_ch;
    logic [cha_pkg::AMT_W-1:0] in_amt;
    logic [cha_pkg::IDX_W-1:0] in_idx;

    assign in_req = s_tuser;
    assign in_det = s_tdata[3:0];
    assign in_ch  = s_tdata[23:4];
    assign in_amt = s_tdata[47:24];
    assign in_idx = s_tdata[55:48];

    // control and request registers
    logic [2:0]                state_reg, state_next;
    logic [DIW-1:0]            det_reg, det_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [cha_pkg::CH_W-1:0]  ch_reg, ch_next;
    logic [cha_pkg::AMT_W-1:0] amt_reg, amt_next;
    logic [cha_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             issue_reg, issue_next;
    logic                      pend_reg, pend_next;
    logic [EW-1:0]             pend_idx_reg, pend_idx_next;
    cha_pkg::res_t             res_reg, res_next;
    logic                      out_valid_reg, out_valid_next;
    cha_pkg::res_t             out_data_reg, out_data_next;

    // per-detector fill counts
    logic [CW-1:0]             count_reg [NUM_DETECTORS];
    logic                      cnt_we;
    logic [CW-1:0]             cnt_wval;

    // entry memories
    logic [cha_pkg::CH_W-1:0]  ch_mem  [DEPTH];
    logic [cha_pkg::SUM_W-1:0] sum_mem [DEPTH];
    logic [cha_pkg::CH_W-1:0]  ch_rdata_reg;
    logic [cha_pkg::SUM_W-1:0] sum_rdata_reg;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;
    logic [AW-1:0]             wr_addr;
    logic [cha_pkg::CH_W-1:0]  ch_wdata;
    logic [cha_pkg::SUM_W-1:0] sum_wdata;

    // helpers
    logic                      in_range;
    logic [CW-1:0]             cnt_now;
    logic                      match;
    logic                      issue;
    logic [cha_pkg::SUM_W:0]   sum_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cha_pkg::M_TDATA_W - $bits(cha_pkg::res_t)){1'b0}}, out_data_reg};

    assign in_range = (int'(in_det) < NUM_DETECTORS);
    assign cnt_now  = in_range ? count_reg[DIW'(in_det)] : '0;
    assign match    = pend_reg && (ch_rdata_reg == ch_reg);
    assign sum_ext  = {1'b0, sum_rdata_reg} + (cha_pkg::SUM_W + 1)'(amt_reg);

    always_comb
    begin
        state_next     = state_reg;
        det_next       = det_reg;
        base_next      = base_reg;
        ch_next        = ch_reg;
        amt_next       = amt_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cnt_we         = 1'b0;
        cnt_wval       = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        wr_addr        = '0;
        ch_wdata       = ch_reg;
        sum_wdata      = '0;
        issue          = 1'b0;

        // output register drains independently of the sequencer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    det_next   = DIW'(in_det);
                    base_next  = AW'(int'(in_det) * ENTRIES);
                    ch_next    = in_ch;
                    amt_next   = in_amt;
                    idx_next   = in_idx;
                    cnt_next   = cnt_now;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    res_next   = '0;
                    state_next = S_PUSH;
                    if (in_range)
                    begin
                        priority if (in_req == cha_pkg::REQ_CLEAR)
                        begin
                            // a clear empties the table by its count alone
                            cnt_we   = 1'b1;
                            cnt_wval = '0;
                        end
                        else if (in_req == cha_pkg::REQ_HIT)
                        begin
                            state_next = S_SCAN;
                        end
                        else if (in_req == cha_pkg::REQ_READ)
                        begin
                            res_next.entry_count = cha_pkg::ECNT_W'(cnt_now);
                            if (CMPW'(in_idx) < CMPW'(cnt_now))
                            begin
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            res_next.entry_count = cha_pkg::ECNT_W'(cnt_now);
                        end
                    end
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = base_reg + AW'(EW'(idx_reg));
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_next.read_valid   = 1'b1;
                res_next.read_channel = ch_rdata_reg;
                res_next.read_sum     = sum_rdata_reg;
                state_next            = S_PUSH;
            end
            S_SCAN:
            begin
                // one read issued per cycle, compared the cycle after
                issue = !match && (issue_reg < cnt_reg);
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = base_reg + AW'(issue_reg[EW-1:0]);
                    issue_next    = issue_reg + CW'(1);
                    pend_idx_next = issue_reg[EW-1:0];
                end
                pend_next = issue;
                if (match)
                begin
                    state_next = S_UPD;
                end
                else if (!pend_reg && !issue)
                begin
                    // channel not listed: append or drop
                    if (cnt_reg < CW'(ENTRIES))
                    begin
                        mem_we               = 1'b1;
                        wr_addr              = base_reg + AW'(cnt_reg[EW-1:0]);
                        ch_wdata             = ch_reg;
                        sum_wdata            = cha_pkg::SUM_W'(amt_reg);
                        cnt_we               = 1'b1;
                        cnt_wval             = cnt_reg + CW'(1);
                        res_next.entry_count = cha_pkg::ECNT_W'(cnt_reg + CW'(1));
                    end
                    else
                    begin
                        res_next.dropped     = 1'b1;
                        res_next.entry_count = cha_pkg::ECNT_W'(cnt_reg);
                    end
                    state_next = S_PUSH;
                end
            end
            S_UPD:
            begin
                mem_we               = 1'b1;
                wr_addr              = base_reg + AW'(pend_idx_reg);
                ch_wdata             = ch_reg;
                sum_wdata            = sum_ext[cha_pkg::SUM_W] ? cha_pkg::SUM_MAX
                                                               : sum_ext[cha_pkg::SUM_W-1:0];
                res_next.merged      = 1'b1;
                res_next.saturated   = sum_ext[cha_pkg::SUM_W];
                res_next.entry_count = cha_pkg::ECNT_W'(cnt_reg);
                state_next           = S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < NUM_DETECTORS; d++)
            begin
                count_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                count_reg[(state_reg == S_IDLE) ? DIW'(in_det) : det_reg] <= cnt_wval;
            end
        end
    end

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        det_reg      <= det_next;
        base_reg     <= base_next;
        ch_reg       <= ch_next;
        amt_reg      <= amt_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // channel memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ch_mem[wr_addr] <= ch_wdata;
        end
        if (rd_en)
        begin
            ch_rdata_reg <= ch_mem[rd_addr];
        end
    end

    // sum memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem[wr_addr] <= sum_wdata;
        end
        if (rd_en)
        begin
            sum_rdata_reg <= sum_mem[rd_addr];
        end
    end

    // writes happen only at the end of a hit scan or in the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_SCAN && !pend_reg) || state_reg == S_UPD))
        else $error("memory write outside a hit update");

    // a result never reports both a merge and a drop, and clipping implies a merge
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!(m_tdata[0] && m_tdata[1]) && (!m_tdata[2] || m_tdata[0])))
        else $error("inconsistent hit flags in result");

    // the scan bound never runs past the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_reg <= cnt_reg && cnt_reg <= CW'(ENTRIES)))
        else $error("scan index beyond table");

    // an accepted request makes the sequencer busy, so the block stops taking requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while one is in flight");

endmodule

>>> dv/cha_response_checker.sv
`timescale 1ns / 100ps
// response checker: mirrors the detector tables and compares every result word
module cha_response_checker #(
    parameter int ENTRIES       = 256,
    parameter int NUM_DETECTORS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // detector[3:0], channel[23:4], amount[47:24], entry_index[55:48]
    input  logic [cha_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [cha_pkg::REQ_W-1:0]     s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // merged[0], dropped[1], saturated[2], read_valid[3], read_channel[23:4],
    // read_sum[55:24], entry_count[64:56], zero[71:65]
    input  logic [cha_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending_count
);

    localparam int RES_W = cha_pkg::ECNT_W + cha_pkg::SUM_W + cha_pkg::CH_W + 4;

    logic [cha_pkg::CH_W-1:0]  chan_tab [NUM_DETECTORS][ENTRIES];
    logic [cha_pkg::SUM_W-1:0] sum_tab  [NUM_DETECTORS][ENTRIES];
    int                        fill_tab [NUM_DETECTORS];
    cha_pkg::res_t             pending_responses [$];

    // response of the tables to one request, updating the mirrored state
    function automatic cha_pkg::res_t table_response(
        input logic [cha_pkg::REQ_W-1:0] req,
        input logic [cha_pkg::DET_W-1:0] det,
        input logic [cha_pkg::CH_W-1:0]  ch,
        input logic [cha_pkg::AMT_W-1:0] amt,
        input logic [cha_pkg::IDX_W-1:0] idx);
        cha_pkg::res_t           r;
        int                      cnt;
        int                      i;
        bit                      found;
        logic [cha_pkg::SUM_W:0] total;
        r = '0;
        if (int'(det) >= NUM_DETECTORS)
            return r;
        cnt = (fill_tab[det] > ENTRIES) ? ENTRIES : fill_tab[det];
        unique case (req)
            cha_pkg::REQ_CLEAR:
            begin
                cnt = 0;
                fill_tab[det] = 0;
            end
            cha_pkg::REQ_HIT:
            begin
                found = 1'b0;
                for (i = 0; i < cnt && !found; i++)
                begin
                    if (chan_tab[det][i] == ch)
                    begin
                        total = {1'b0, sum_tab[det][i]} + (cha_pkg::SUM_W + 1)'(amt);
                        if (total > {1'b0, cha_pkg::SUM_MAX})
                        begin
                            sum_tab[det][i] = cha_pkg::SUM_MAX;
                            r.saturated = 1'b1;
                        end
                        else
                        begin
                            sum_tab[det][i] = total[cha_pkg::SUM_W-1:0];
                        end
                        r.merged = 1'b1;
                        found    = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (cnt < ENTRIES)
                    begin
                        chan_tab[det][cnt] = ch;
                        sum_tab[det][cnt]  = cha_pkg::SUM_W'(amt);
                        cnt++;
                        fill_tab[det] = cnt;
                    end
                    else
                    begin
                        r.dropped = 1'b1;
                    end
                end
            end
            cha_pkg::REQ_READ:
            begin
                if (int'(idx) < cnt)
                begin
                    r.read_valid   = 1'b1;
                    r.read_channel = chan_tab[det][idx];
                    r.read_sum     = sum_tab[det][idx];
                end
            end
            default: ;
        endcase
        r.entry_count = cnt[cha_pkg::ECNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [cha_pkg::SUM_W-1:0] want,
                               input logic [cha_pkg::SUM_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cha_pkg::res_t want;
        cha_pkg::res_t got;
        cha_pkg::res_t pred;
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DETECTORS; d++)
                fill_tab[d] = 0;
            pending_responses.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = cha_pkg::res_t'(m_tdata[RES_W-1:0]);
                if (pending_responses.size() == 0)
                begin
                    $error("result word with no request pending, m_tdata 0x%0h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_responses.pop_front();
                    check_field("merged", cha_pkg::SUM_W'(want.merged),
                                cha_pkg::SUM_W'(got.merged));
                    check_field("dropped", cha_pkg::SUM_W'(want.dropped),
                                cha_pkg::SUM_W'(got.dropped));
                    check_field("saturated", cha_pkg::SUM_W'(want.saturated),
                                cha_pkg::SUM_W'(got.saturated));
                    check_field("read_valid", cha_pkg::SUM_W'(want.read_valid),
                                cha_pkg::SUM_W'(got.read_valid));
                    check_field("read_channel", cha_pkg::SUM_W'(want.read_channel),
                                cha_pkg::SUM_W'(got.read_channel));
                    check_field("read_sum", want.read_sum, got.read_sum);
                    check_field("entry_count", cha_pkg::SUM_W'(want.entry_count),
                                cha_pkg::SUM_W'(got.entry_count));
                    check_field("zero", '0,
                                cha_pkg::SUM_W'(m_tdata[cha_pkg::M_TDATA_W-1:RES_W]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                pred = table_response(s_tuser, s_tdata[3:0], s_tdata[23:4],
                                      s_tdata[47:24], s_tdata[55:48]);
                pending_responses.insert(pending_responses.size(), pred);
            end
        end
        pending_count = pending_responses.size();
    end

endmodule

>>> dv/tb_channel_hit_accumulator_top.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, request stimulus and verdict for the hit accumulator
module tb_channel_hit_accumulator_top;

    localparam int ENTRIES       = 256;
    localparam int NUM_DETECTORS = 16;
    localparam int RANDOM_WORDS  = 1600;
    localparam int HOLD_CYCLES   = 400;
    // req_type code that the block does not know; it only reports the count
    localparam logic [cha_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cha_pkg::S_TDATA_W-1:0] s_tdata;
    logic [cha_pkg::REQ_W-1:0]     s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cha_pkg::M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int words_sent;
    int words_back;
    // set during a stretch where neither side idles
    bit no_idle;

    channel_hit_accumulator_top #(
        .ENTRIES      (ENTRIES),
        .NUM_DETECTORS(NUM_DETECTORS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    cha_response_checker #(
        .ENTRIES      (ENTRIES),
        .NUM_DETECTORS(NUM_DETECTORS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (full-table scans on every word)
    initial
    begin
        #20_000_000;
        $display("channel_hit_accumulator_top verification failed");
        $finish;
    end

    // result words taken, used to place the long receiver hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            words_back <= words_back + 1;
    end

    // receiver: random back-pressure, one long hold-off so the block fills up
    // and stalls its input while the sender keeps offering words
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left  = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && words_back >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 20);
            end
        end
    end

    // offer one request word, at times after a random gap, and wait until taken
    task automatic issue_request(input logic [cha_pkg::REQ_W-1:0] req,
                                 input logic [cha_pkg::DET_W-1:0] det,
                                 input logic [cha_pkg::CH_W-1:0]  ch,
                                 input logic [cha_pkg::AMT_W-1:0] amt,
                                 input logic [cha_pkg::IDX_W-1:0] idx);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idx, amt, ch, det};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    initial
    begin
        int                        i;
        int                        n;
        int                        kind;
        int                        target;
        bit                        fill_done;
        bit                        sat_done;
        logic [cha_pkg::DET_W-1:0] det;
        logic [cha_pkg::CH_W-1:0]  base;
        logic [cha_pkg::CH_W-1:0]  ch;
        logic [cha_pkg::AMT_W-1:0] amt;
        logic [cha_pkg::IDX_W-1:0] idx;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = cha_pkg::REQ_CLEAR;
        no_idle    = 1'b0;
        words_sent = 0;
        fill_done  = 1'b0;
        sat_done   = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part: empty-table read, unknown request, field extremes,
        // merge onto an existing entry, reads in and out of range, clears
        issue_request(cha_pkg::REQ_READ, 4'd0, '0, '0, 8'd0);
        issue_request(REQ_UNKNOWN, 4'd0, '0, '0, '0);
        issue_request(cha_pkg::REQ_HIT, 4'd0, 20'd0, 24'd0, '0);
        issue_request(cha_pkg::REQ_HIT, 4'd0, 20'hFFFFF, 24'hFFFFFF, '0);
        issue_request(cha_pkg::REQ_HIT, 4'd0, 20'd0, 24'hFFFFFF, '0);
        issue_request(cha_pkg::REQ_HIT, 4'd0, 20'hFFFFF, 24'h000001, '0);
        issue_request(cha_pkg::REQ_READ, 4'd0, '0, '0, 8'd0);
        issue_request(cha_pkg::REQ_READ, 4'd0, '0, '0, 8'd1);
        issue_request(cha_pkg::REQ_READ, 4'd0, '0, '0, 8'd2);
        issue_request(cha_pkg::REQ_READ, 4'd0, 20'hFFFFF, 24'hFFFFFF, 8'd255);
        issue_request(REQ_UNKNOWN, 4'd0, 20'hFFFFF, 24'hFFFFFF, 8'hFF);
        issue_request(cha_pkg::REQ_HIT, 4'd15, 20'h5A5A5, 24'h000001, 8'hFF);
        issue_request(cha_pkg::REQ_READ, 4'd15, 20'hFFFFF, 24'hFFFFFF, 8'd0);
        issue_request(REQ_UNKNOWN, 4'd15, '0, '0, '0);
        issue_request(cha_pkg::REQ_CLEAR, 4'd0, 20'hFFFFF, 24'hFFFFFF, 8'hFF);
        issue_request(cha_pkg::REQ_READ, 4'd0, '0, '0, 8'd0);
        issue_request(cha_pkg::REQ_CLEAR, 4'd7, '0, '0, '0);
        issue_request(cha_pkg::REQ_HIT, 4'd0, 20'hFFFFF, 24'h800000, '0);
        issue_request(cha_pkg::REQ_CLEAR, 4'd15, '0, '0, '0);
        issue_request(cha_pkg::REQ_READ, 4'd15, '0, '0, 8'd0);

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            if (!fill_done && words_sent > 400)
            begin
                // fill one table to the brim, overflow it, merge on a full table
                fill_done = 1'b1;
                det  = 4'($urandom);
                base = 20'($urandom);
                issue_request(cha_pkg::REQ_CLEAR, det, '0, '0, '0);
                for (i = 0; i < ENTRIES + 4; i++)
                    issue_request(cha_pkg::REQ_HIT, det, base ^ 20'(i), 24'($urandom),
                                  8'($urandom));
                issue_request(cha_pkg::REQ_HIT, det, base ^ 20'(ENTRIES - 1),
                              24'($urandom), '0);
                issue_request(cha_pkg::REQ_HIT, det, base, 24'($urandom), '0);
                issue_request(cha_pkg::REQ_READ, det, '0, '0, 8'd0);
                issue_request(cha_pkg::REQ_READ, det, '0, '0, 8'(ENTRIES - 1));
                issue_request(REQ_UNKNOWN, det, '0, '0, '0);
                repeat (6)
                    issue_request(cha_pkg::REQ_READ, det, 20'($urandom), 24'($urandom),
                                  8'($urandom));
            end
            else if (!sat_done && words_sent > 900)
            begin
                // drive one sum into saturation, with no idling on either side
                sat_done = 1'b1;
                no_idle  = 1'b1;
                det = 4'($urandom);
                ch  = 20'($urandom);
                issue_request(cha_pkg::REQ_CLEAR, det, '0, '0, '0);
                repeat (260)
                    issue_request(cha_pkg::REQ_HIT, det, ch, 24'hFFFFFF, 8'($urandom));
                issue_request(cha_pkg::REQ_READ, det, '0, '0, 8'd0);
                no_idle = 1'b0;
            end
            else if ($urandom_range(0, 99) < 80)
            begin
                // one event on one detector: mostly cleared first, then hits on
                // a small channel pool so merges are common, plus reads, unknown requests and clears
                det  = 4'($urandom);
                base = 20'($urandom);
                if ($urandom_range(0, 99) < 80)
                    issue_request(cha_pkg::REQ_CLEAR, det, 20'($urandom), 24'($urandom),
                                  8'($urandom));
                n = $urandom_range(4, 40);
                repeat (n)
                begin
                    kind = $urandom_range(0, 99);
                    ch   = ($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                       : base ^ 20'($urandom_range(0, 15));
                    case ($urandom_range(0, 19))
                        0:       amt = 24'hFFFFFF;
                        1:       amt = 24'd0;
                        default: amt = 24'($urandom);
                    endcase
                    idx = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 20));
                    if (kind < 70)
                        issue_request(cha_pkg::REQ_HIT, det, ch, amt, idx);
                    else if (kind < 93)
                        issue_request(cha_pkg::REQ_READ, det, ch, amt, idx);
                    else if (kind < 97)
                        issue_request(REQ_UNKNOWN, det, ch, amt, idx);
                    else
                        issue_request(cha_pkg::REQ_CLEAR, det, ch, amt, idx);
                end
            end
            else
            begin
                // noise: any request type with any field values
                n = $urandom_range(1, 10);
                repeat (n)
                    issue_request(2'($urandom), 4'($urandom), 20'($urandom),
                                  24'($urandom), 8'($urandom));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain every expected word, then allow one full-table scan more
        while (pending_count != 0) @(posedge clk);
        repeat (ENTRIES + 20) @(posedge clk);

        if (fail_count == 0)
            $display("channel_hit_accumulator_top verification clean");
        else
            $display("channel_hit_accumulator_top verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/cha_pkg.sv
rtl/core/channel_hit_accumulator_top.sv
dv/cha_response_checker.sv
dv/tb_channel_hit_accumulator_top.sv
